// ===== sv/ssct_pkg.sv =====
package ssct_pkg;

  // coordinate and intermediate widths
  localparam int CW      = 24;           // Q12.12 coordinate
  localparam int RW      = CW - 1;       // radius
  localparam int DW      = CW + 1;       // coordinate difference
  localparam int PW      = 2 * DW;       // product of two differences
  localparam int SW      = PW + 1;       // three-term dot product
  localparam int WW      = 2 * SW;       // product of two dot products
  localparam int QW      = WW - 1;       // divider remainder
  localparam int T_BITS  = 16;           // fraction bits of segment parameter
  localparam int TW      = T_BITS + 1;   // segment parameter, 0 .. 1.0
  localparam int RRW     = 2 * RW;       // radius squared
  localparam int DSQ_W   = 53;           // reported squared distance
  localparam int CFG_IDX_W = 3;

  localparam logic [TW-1:0] T_ONE = {1'b1, {T_BITS{1'b0}}};

  // request kinds
  localparam logic REQ_CAPSULE = 1'b1;

  // configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_X,
    REG_START_Y,
    REG_START_Z,
    REG_END_X,
    REG_END_Y,
    REG_END_Z
  } cfg_reg_t;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [DW-1:0] diff_t;
  typedef logic signed [SW-1:0] dot_t;
  typedef logic signed [WW-1:0] wide_t;
  typedef logic [TW-1:0]        tval_t;
  typedef coord_t [2:0]         cvec_t;
  typedef diff_t [2:0]          dvec_t;

endpackage

// ===== sv/ssct_if.sv =====
// request channel
interface ssct_in_if import ssct_pkg::*; ();
  logic           valid;
  logic           ready;
  logic           req_type;
  coord_t         obj_ax;
  coord_t         obj_ay;
  coord_t         obj_az;
  coord_t         obj_bx;
  coord_t         obj_by;
  coord_t         obj_bz;
  logic [RW-1:0]  radius;

  modport source (
    output valid, req_type, obj_ax, obj_ay, obj_az, obj_bx, obj_by, obj_bz, radius,
    input  ready
  );
  modport sink (
    input  valid, req_type, obj_ax, obj_ay, obj_az, obj_bx, obj_by, obj_bz, radius,
    output ready
  );
endinterface

// result channel
interface ssct_out_if import ssct_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              hit;
  coord_t            near_x;
  coord_t            near_y;
  coord_t            near_z;
  logic [DSQ_W-1:0]  dist_sq;

  modport source (
    output valid, hit, near_x, near_y, near_z, dist_sq,
    input  ready
  );
  modport sink (
    input  valid, hit, near_x, near_y, near_z, dist_sq,
    output ready
  );
endinterface

// ===== sv/ssct_wmul.sv =====
// signed dot x dot multiplier, split in four partial products, two stages
module ssct_wmul import ssct_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  dot_t  a,
  input  dot_t  b,
  output wide_t p
);

  localparam int LO   = (SW + 1) / 2;
  localparam int HI   = SW - LO;
  localparam int HH_W = 2 * HI;
  localparam int HL_W = HI + LO + 1;
  localparam int LL_W = 2 * LO;

  logic signed [HH_W-1:0] hh_r, hh_nxt;
  logic signed [HL_W-1:0] hl_r, hl_nxt;
  logic signed [HL_W-1:0] lh_r, lh_nxt;
  logic [LL_W-1:0]        ll_r, ll_nxt;
  wide_t                  p_r, p_nxt;

  // partial products
  always_comb begin
    hh_nxt = HH_W'($signed(a[SW-1:LO])) * HH_W'($signed(b[SW-1:LO]));
    hl_nxt = HL_W'($signed(a[SW-1:LO])) * HL_W'($signed({1'b0, b[LO-1:0]}));
    lh_nxt = HL_W'($signed({1'b0, a[LO-1:0]})) * HL_W'($signed(b[SW-1:LO]));
    ll_nxt = LL_W'(a[LO-1:0]) * LL_W'(b[LO-1:0]);
  end

  // recombine
  always_comb begin
    p_nxt = (WW'(hh_r) <<< (2 * LO)) + (WW'(hl_r) <<< LO) + (WW'(lh_r) <<< LO)
          + WW'(ll_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hh_r <= hh_nxt;
      hl_r <= hl_nxt;
      lh_r <= lh_nxt;
      ll_r <= ll_nxt;
      p_r  <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

// ===== sv/ssct_div.sv =====
// segment parameter: floor(2^16 * num / den) clamped to [0, 1.0]
// one check stage, then one restoring quotient bit per stage
module ssct_div import ssct_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  wide_t num,
  input  wide_t den,
  output tval_t t
);

  logic [QW-1:0]     rem_r  [T_BITS+1];
  logic [QW-1:0]     rem_nxt[T_BITS+1];
  logic [QW-1:0]     den_r  [T_BITS+1];
  logic [QW-1:0]     den_nxt[T_BITS+1];
  logic [T_BITS-1:0] q_r    [T_BITS+1];
  logic [T_BITS-1:0] q_nxt  [T_BITS+1];
  logic              zero_r  [T_BITS+1];
  logic              zero_nxt[T_BITS+1];
  logic              one_r   [T_BITS+1];
  logic              one_nxt [T_BITS+1];

  always_comb begin
    logic [QW-1:0] sh;
    logic          ge;
    // degenerate and clamped cases
    zero_nxt[0] = (den == '0) || num[WW-1] || (num == '0);
    one_nxt[0]  = (num >= den);
    rem_nxt[0]  = num[QW-1:0];
    den_nxt[0]  = den[QW-1:0];
    q_nxt[0]    = '0;
    // quotient bit steps
    for (int k = 1; k <= T_BITS; k++) begin
      sh          = {rem_r[k-1][QW-2:0], 1'b0};
      ge          = (sh >= den_r[k-1]);
      rem_nxt[k]  = ge ? sh - den_r[k-1] : sh;
      den_nxt[k]  = den_r[k-1];
      q_nxt[k]    = {q_r[k-1][T_BITS-2:0], ge};
      zero_nxt[k] = zero_r[k-1];
      one_nxt[k]  = one_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      den_r  <= den_nxt;
      q_r    <= q_nxt;
      zero_r <= zero_nxt;
      one_r  <= one_nxt;
    end
  end

  assign t = zero_r[T_BITS] ? '0 :
             one_r[T_BITS]  ? T_ONE : {1'b0, q_r[T_BITS]};

endmodule

// ===== sv/ssct_point.sv =====
// point on a segment: base + floor(dir * t / 2^16), two stages
module ssct_point import ssct_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  cvec_t base,
  input  dvec_t dir,
  input  tval_t t,
  output cvec_t pt
);

  localparam int PRW = DW + TW + 1;

  logic signed [PRW-1:0] prod_r  [3];
  logic signed [PRW-1:0] prod_nxt[3];
  cvec_t                 base_r;
  cvec_t                 pt_r, pt_nxt;

  // scale direction
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_nxt[i] = PRW'($signed(dir[i])) * PRW'($signed({1'b0, t}));
    end
  end

  // floor shift and offset
  always_comb begin
    logic signed [PRW-1:0] ext;
    for (int i = 0; i < 3; i++) begin
      ext       = PRW'($signed(base_r[i])) + (prod_r[i] >>> T_BITS);
      pt_nxt[i] = ext[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      base_r <= base;
      pt_r   <= pt_nxt;
    end
  end

  assign pt = pt_r;

endmodule

// ===== sv/ssct_front.sv =====
// dot products and first quotient operands, six stages
module ssct_front import ssct_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  logic  typ,
  input  cvec_t a,
  input  cvec_t b,
  input  cvec_t s,
  input  cvec_t e,
  output wide_t num,
  output wide_t den,
  output dvec_t d2,
  output dot_t  d22
);

  diff_t               d1_r[3];
  diff_t               w_r [3];
  dvec_t               d2_st_r [1:6];
  logic                typ_st_r[1:5];
  logic signed [PW-1:0] m11_r[3], m22_r[3], m12_r[3], m1w_r[3], m2w_r[3];
  dot_t                d11_r, d22_r, d12_r, d1w_r, d2w_r;
  dot_t                d11_st_r[4:5];
  dot_t                d1w_st_r[4:5];
  dot_t                d22_st_r[4:6];
  wide_t               p_dd, p_cc, p_cw, p_wd;
  wide_t               num_r, num_nxt, den_r, den_nxt;

  // stage 1: direction vectors
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d1_r[i]       <= DW'($signed(e[i])) - DW'($signed(s[i]));
        d2_st_r[1][i] <= DW'($signed(b[i])) - DW'($signed(a[i]));
        w_r[i]        <= DW'($signed(s[i])) - DW'($signed(a[i]));
      end
      typ_st_r[1] <= typ;
    end
  end

  // stage 2: component products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m11_r[i] <= PW'(d1_r[i]) * PW'(d1_r[i]);
        m22_r[i] <= PW'($signed(d2_st_r[1][i])) * PW'($signed(d2_st_r[1][i]));
        m12_r[i] <= PW'(d1_r[i]) * PW'($signed(d2_st_r[1][i]));
        m1w_r[i] <= PW'(d1_r[i]) * PW'(w_r[i]);
        m2w_r[i] <= PW'($signed(d2_st_r[1][i])) * PW'(w_r[i]);
      end
    end
  end

  // stage 3: dot sums
  always_ff @(posedge clk) begin
    if (en) begin
      d11_r <= SW'(m11_r[0]) + SW'(m11_r[1]) + SW'(m11_r[2]);
      d22_r <= SW'(m22_r[0]) + SW'(m22_r[1]) + SW'(m22_r[2]);
      d12_r <= SW'(m12_r[0]) + SW'(m12_r[1]) + SW'(m12_r[2]);
      d1w_r <= SW'(m1w_r[0]) + SW'(m1w_r[1]) + SW'(m1w_r[2]);
      d2w_r <= SW'(m2w_r[0]) + SW'(m2w_r[1]) + SW'(m2w_r[2]);
    end
  end

  // stages 4-5: wide products
  ssct_wmul u_mul_dd (.clk(clk), .en(en), .a(d11_r), .b(d22_r), .p(p_dd));
  ssct_wmul u_mul_cc (.clk(clk), .en(en), .a(d12_r), .b(d12_r), .p(p_cc));
  ssct_wmul u_mul_cw (.clk(clk), .en(en), .a(d12_r), .b(d2w_r), .p(p_cw));
  ssct_wmul u_mul_wd (.clk(clk), .en(en), .a(d1w_r), .b(d22_r), .p(p_wd));

  // stage 6: quotient operands, sphere uses the plain projection
  always_comb begin
    if (typ_st_r[5] == REQ_CAPSULE) begin
      num_nxt = p_cw - p_wd;
      den_nxt = p_dd - p_cc;
    end else begin
      num_nxt = -WW'(d1w_st_r[5]);
      den_nxt = WW'(d11_st_r[5]);
    end
  end

  // side data alignment
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 2; k <= 6; k++) d2_st_r[k] <= d2_st_r[k-1];
      for (int k = 2; k <= 5; k++) typ_st_r[k] <= typ_st_r[k-1];
      d11_st_r[4] <= d11_r;
      d11_st_r[5] <= d11_st_r[4];
      d1w_st_r[4] <= d1w_r;
      d1w_st_r[5] <= d1w_st_r[4];
      d22_st_r[4] <= d22_r;
      d22_st_r[5] <= d22_st_r[4];
      d22_st_r[6] <= d22_st_r[5];
      num_r       <= num_nxt;
      den_r       <= den_nxt;
    end
  end

  assign num = num_r;
  assign den = den_r;
  assign d2  = d2_st_r[6];
  assign d22 = d22_st_r[6];

endmodule

// ===== sv/segment_sphere_capsule_test.sv =====
// Segment versus sphere/capsule test in signed Q12.12. The query segment is
// set through six configuration registers; each request carries one sphere
// (centre, radius) or one capsule (axis ends, radius) and yields one result:
// hit flag, closest point on the query segment and squared distance (Q24.24).
// The datapath is a fixed pipeline of 51 register stages and takes one request
// every clock cycle while it is not frozen. The depth is set by the two 16-step
// quotient pipelines (one bit per stage) and the split wide multipliers. When the
// result register is held by the consumer the whole pipeline freezes and input
// ready drops.
// Configuration must only be written with the pipeline empty.
module segment_sphere_capsule_test import ssct_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  ssct_in_if.sink              in_chan,
  ssct_out_if.source           out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CW-1:0]        cfg_data
);

  localparam int FRONT_LAT = 6;
  localparam int DIV_LAT   = T_BITS + 1;
  localparam int PT_LAT    = 2;
  localparam int K_FRONT   = FRONT_LAT;
  localparam int K_DIV1    = K_FRONT + DIV_LAT;
  localparam int K_PT1     = K_DIV1 + PT_LAT;
  localparam int K_REL     = K_PT1 + 1;
  localparam int K_DOT     = K_REL + 1;
  localparam int K_SUM     = K_DOT + 1;
  localparam int K_DIV2    = K_SUM + DIV_LAT;
  localparam int K_PT2     = K_DIV2 + PT_LAT;
  localparam int K_DV      = K_PT2 + 1;
  localparam int K_SQ      = K_DV + 1;
  localparam int K_OUT     = K_SQ + 1;

  localparam logic [DSQ_W-1:0] DIST_BOUND = DSQ_W'(3) << (2 * (DW - 1));

  typedef struct packed {
    logic          vld;
    logic          typ;
    cvec_t         a;
    cvec_t         b;
    logic [RW-1:0] r;
    dvec_t         d2;
    dot_t          d22;
    cvec_t         p;
  } side_t;

  cvec_t  seg_s_r, seg_e_r;
  dvec_t  d1;
  side_t  side_r  [K_OUT+1];
  side_t  side_nxt[K_OUT+1];
  logic   en;

  wide_t  f_num, f_den;
  dvec_t  f_d2;
  dot_t   f_d22;
  tval_t  t1, t2;
  cvec_t  pt1, pt2;

  diff_t                rel_r [3];
  logic signed [PW-1:0] m2_r  [3];
  dot_t                 num2_r;
  diff_t                dv_r  [3];
  logic signed [PW-1:0] sq_r  [3];
  logic [RRW-1:0]       rr_r;
  logic [DSQ_W-1:0]     dist_r, dist_nxt;
  logic                 hit_r;
  logic [K_OUT:0]       vld_vec;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_s_r <= '0;
      seg_e_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_START_X: seg_s_r[0] <= cfg_data;
        REG_START_Y: seg_s_r[1] <= cfg_data;
        REG_START_Z: seg_s_r[2] <= cfg_data;
        REG_END_X:   seg_e_r[0] <= cfg_data;
        REG_END_Y:   seg_e_r[1] <= cfg_data;
        REG_END_Z:   seg_e_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // query direction; the user must keep it static while transactions are in flight, the block does not enforce this
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d1[i] = DW'($signed(seg_e_r[i])) - DW'($signed(seg_s_r[i]));
    end
  end

  // global advance: the result register is free or being taken
  assign en            = !side_r[K_OUT].vld || out_chan.ready;
  assign in_chan.ready = en;

  // side data travelling with each transaction
  always_comb begin
    side_nxt[0].vld = in_chan.valid;
    side_nxt[0].typ = in_chan.req_type;
    side_nxt[0].a   = {in_chan.obj_az, in_chan.obj_ay, in_chan.obj_ax};
    side_nxt[0].b   = {in_chan.obj_bz, in_chan.obj_by, in_chan.obj_bx};
    side_nxt[0].r   = in_chan.radius;
    side_nxt[0].d2  = '0;
    side_nxt[0].d22 = '0;
    side_nxt[0].p   = '0;
    for (int k = 1; k <= K_OUT; k++) side_nxt[k] = side_r[k-1];
    side_nxt[K_FRONT+1].d2  = f_d2;
    side_nxt[K_FRONT+1].d22 = f_d22;
    side_nxt[K_REL].p       = pt1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= K_OUT; k++) side_r[k].vld <= 1'b0;
    end else if (en) begin
      side_r <= side_nxt;
    end
  end

  // quotient operands for the query parameter
  ssct_front u_front (
    .clk(clk), .en(en), .typ(side_r[0].typ), .a(side_r[0].a), .b(side_r[0].b),
    .s(seg_s_r), .e(seg_e_r), .num(f_num), .den(f_den), .d2(f_d2), .d22(f_d22)
  );

  // point on the query segment
  ssct_div   u_div1 (.clk(clk), .en(en), .num(f_num), .den(f_den), .t(t1));
  ssct_point u_pt1  (.clk(clk), .en(en), .base(seg_s_r), .dir(d1), .t(t1), .pt(pt1));

  // projection of that point onto the capsule axis
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        rel_r[i] <= DW'($signed(pt1[i])) - DW'($signed(side_r[K_PT1].a[i]));
        m2_r[i]  <= PW'(rel_r[i]) * PW'($signed(side_r[K_REL].d2[i]));
      end
      num2_r <= SW'(m2_r[0]) + SW'(m2_r[1]) + SW'(m2_r[2]);
    end
  end

  ssct_div u_div2 (
    .clk(clk), .en(en), .num(WW'(num2_r)), .den(WW'(side_r[K_SUM].d22)), .t(t2)
  );
  ssct_point u_pt2 (
    .clk(clk), .en(en), .base(side_r[K_DIV2].a), .dir(side_r[K_DIV2].d2), .t(t2),
    .pt(pt2)
  );

  // separation vector, squares and compare
  always_comb begin
    dist_nxt = DSQ_W'(sq_r[0]) + DSQ_W'(sq_r[1]) + DSQ_W'(sq_r[2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (side_r[K_PT2].typ == REQ_CAPSULE) begin
          dv_r[i] <= DW'($signed(side_r[K_PT2].p[i])) - DW'($signed(pt2[i]));
        end else begin
          dv_r[i] <= DW'($signed(side_r[K_PT2].a[i])) - DW'($signed(side_r[K_PT2].p[i]));
        end
        sq_r[i] <= PW'(dv_r[i]) * PW'(dv_r[i]);
      end
      rr_r   <= RRW'(side_r[K_DV].r) * RRW'(side_r[K_DV].r);
      dist_r <= dist_nxt;
      hit_r  <= (dist_nxt <= DSQ_W'(rr_r));
    end
  end

  // result channel
  assign out_chan.valid   = side_r[K_OUT].vld;
  assign out_chan.hit     = hit_r;
  assign out_chan.near_x  = side_r[K_OUT].p[0];
  assign out_chan.near_y  = side_r[K_OUT].p[1];
  assign out_chan.near_z  = side_r[K_OUT].p[2];
  assign out_chan.dist_sq = dist_r;

  always_comb begin
    for (int k = 0; k <= K_OUT; k++) vld_vec[k] = side_r[k].vld;
  end

  // a frozen pipeline keeps every occupied slot
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_vec))
    else $error("pipeline occupancy changed during stall");

  // separation components stay within the coordinate span
  a_dist_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> dist_r <= DIST_BOUND)
    else $error("squared distance beyond coordinate span");

  // a hit never reports a distance too wide for the radius-squared width
  a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && hit_r |-> dist_r < (DSQ_W'(1) << RRW))
    else $error("hit with distance beyond any radius");

endmodule

// ===== dv/tb_segment_sphere_capsule_test.sv =====
`timescale 1ns / 100ps

module tb_segment_sphere_capsule_test import ssct_pkg::*; ();

  localparam int  LATENCY   = 50;
  localparam int  LIMIT     = 1000000;
  localparam int  PHASE_LEN = 360;
  localparam logic REQ_SPHERE = 1'b0;

  typedef longint v3_t [3];

  typedef struct {
    logic           kind;
    coord_t         a [3];
    coord_t         b [3];
    logic [RW-1:0]  radius;
  } query_t;

  typedef struct {
    logic             hit;
    coord_t           near [3];
    logic [DSQ_W-1:0] dist_sq;
  } answer_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CW-1:0] cfg_data;

  ssct_in_if  in_if ();
  ssct_out_if out_if ();

  segment_sphere_capsule_test u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  query_t  pending_q [$];
  answer_t answers_q [$];
  coord_t  seg_regs [6];
  bit      hold_tx;
  bit      quiet;
  int      errors;
  int      n_sphere, n_capsule, n_hit, n_sat, n_checked;
  int      cycles;
  int      tx_gap, rx_gap;

  // clock
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // geometry predictor
  function automatic longint dot3(v3_t x, v3_t y);
    return x[0] * y[0] + x[1] * y[1] + x[2] * y[2];
  endfunction

  function automatic longint seg_param(logic signed [127:0] num, logic signed [127:0] den);
    if (den == 0 || num <= 0) return 0;
    if (num >= den) return longint'(T_ONE);
    return longint'((num <<< T_BITS) / den);
  endfunction

  function automatic v3_t along(v3_t base, v3_t dir, longint t);
    v3_t p;
    for (int i = 0; i < 3; i++) p[i] = base[i] + ((dir[i] * t) >>> T_BITS);
    return p;
  endfunction

  function automatic v3_t project_onto(v3_t u, v3_t dir, v3_t x);
    v3_t rel;
    for (int i = 0; i < 3; i++) rel[i] = x[i] - u[i];
    return along(u, dir, seg_param(dot3(dir, rel), dot3(dir, dir)));
  endfunction

  function automatic answer_t closest_approach(query_t q);
    v3_t s, d1, a, d2, w, p, c, dv;
    logic signed [127:0] d11, d22, d12, d1w, d2w, num, den;
    logic [63:0] sum, m, rr;
    bit far;
    answer_t r;
    for (int i = 0; i < 3; i++) begin
      s[i]  = seg_regs[i];
      d1[i] = longint'(seg_regs[3 + i]) - s[i];
      a[i]  = q.a[i];
      d2[i] = longint'(q.b[i]) - a[i];
      w[i]  = s[i] - a[i];
    end
    if (q.kind == REQ_SPHERE) begin
      p = project_onto(s, d1, a);
      for (int i = 0; i < 3; i++) dv[i] = a[i] - p[i];
    end else begin
      d11 = dot3(d1, d1);
      d22 = dot3(d2, d2);
      d12 = dot3(d1, d2);
      d1w = dot3(d1, w);
      d2w = dot3(d2, w);
      den = d11 * d22 - d12 * d12;
      num = d12 * d2w - d1w * d22;
      p = along(s, d1, seg_param(num, den));
      c = project_onto(a, d2, p);
      for (int i = 0; i < 3; i++) dv[i] = p[i] - c[i];
    end
    sum = 0;
    far = 0;
    for (int i = 0; i < 3; i++) begin
      m = dv[i] < 0 ? -dv[i] : dv[i];
      if (m >= 64'h8000_0000) far = 1;
      else sum += m * m;
    end
    rr = 64'(q.radius) * 64'(q.radius);
    r.hit = !far && sum <= rr;
    for (int i = 0; i < 3; i++) r.near[i] = coord_t'(p[i]);
    r.dist_sq = (far || sum > {DSQ_W{1'b1}}) ? {DSQ_W{1'b1}} : sum[DSQ_W-1:0];
    return r;
  endfunction

  // request driver, predicts on each accepted transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      tx_gap <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        query_t cur;
        cur.kind = in_if.req_type;
        cur.a = '{in_if.obj_ax, in_if.obj_ay, in_if.obj_az};
        cur.b = '{in_if.obj_bx, in_if.obj_by, in_if.obj_bz};
        cur.radius = in_if.radius;
        answers_q.push_back(closest_approach(cur));
        if (cur.kind == REQ_SPHERE) n_sphere++;
        else n_capsule++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          in_if.valid <= 1'b0;
        end else if (!hold_tx && pending_q.size() > 0 && (quiet || $urandom_range(0, 19) != 0)) begin
          query_t nx;
          nx = pending_q.pop_front();
          in_if.valid    <= 1'b1;
          in_if.req_type <= nx.kind;
          in_if.obj_ax   <= nx.a[0];
          in_if.obj_ay   <= nx.a[1];
          in_if.obj_az   <= nx.a[2];
          in_if.obj_bx   <= nx.b[0];
          in_if.obj_by   <= nx.b[1];
          in_if.obj_bz   <= nx.b[2];
          in_if.radius   <= nx.radius;
        end else begin
          in_if.valid <= 1'b0;
          if (!quiet) tx_gap <= $urandom_range(1, 17);
        end
      end
    end
  end

  // result monitor with random backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      rx_gap <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (answers_q.size() == 0) begin
          errors++;
          $display("%0t: result transaction with nothing expected", $time);
        end else begin
          answer_t e;
          e = answers_q.pop_front();
          n_checked++;
          if (e.hit) n_hit++;
          if (e.dist_sq == {DSQ_W{1'b1}}) n_sat++;
          if (out_if.hit !== e.hit) begin
            errors++;
            $display("%0t: hit expected %0d actual %0d", $time, e.hit, out_if.hit);
          end
          if (out_if.near_x !== e.near[0]) begin
            errors++;
            $display("%0t: near_x expected %0d actual %0d", $time, e.near[0], out_if.near_x);
          end
          if (out_if.near_y !== e.near[1]) begin
            errors++;
            $display("%0t: near_y expected %0d actual %0d", $time, e.near[1], out_if.near_y);
          end
          if (out_if.near_z !== e.near[2]) begin
            errors++;
            $display("%0t: near_z expected %0d actual %0d", $time, e.near[2], out_if.near_z);
          end
          if (out_if.dist_sq !== e.dist_sq) begin
            errors++;
            $display("%0t: dist_sq expected %0d actual %0d", $time, e.dist_sq, out_if.dist_sq);
          end
        end
      end
      if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        out_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 24) == 0) begin
        rx_gap <= $urandom_range(0, 16);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("segment_sphere_capsule_test verification failed");
      $finish;
    end
  end

  function automatic coord_t pick_coord(int mode);
    case (mode)
      0:       return coord_t'($urandom);
      1:       return coord_t'($signed($urandom_range(0, 32768)) - 16384);
      default: begin
        case ($urandom_range(0, 3))
          0:       return coord_t'(-8388608);
          1:       return coord_t'(8388607);
          2:       return coord_t'(0);
          default: return coord_t'(-1);
        endcase
      end
    endcase
  endfunction

  function automatic query_t random_query();
    query_t q;
    int mode, sel;
    sel = $urandom_range(0, 99);
    mode = sel < 70 ? 1 : (sel < 85 ? 0 : 2);
    q.kind = 1'($urandom_range(0, 1));
    for (int i = 0; i < 3; i++) begin
      q.a[i] = pick_coord(mode == 2 ? $urandom_range(0, 2) : mode);
      q.b[i] = pick_coord(mode == 2 ? $urandom_range(0, 2) : mode);
    end
    // parallel or zero-length capsule axes
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      for (int i = 0; i < 3; i++) q.b[i] = q.a[i] + seg_regs[3 + i] - seg_regs[i];
    end else if (sel == 1) begin
      q.b = q.a;
    end
    sel = $urandom_range(0, 19);
    if (sel == 0) q.radius = '0;
    else if (sel == 1) q.radius = '1;
    else if (mode == 1) q.radius = RW'($urandom_range(0, 32768));
    else q.radius = RW'($urandom);
    return q;
  endfunction

  function automatic query_t make_query(logic kind, coord_t ax, coord_t ay, coord_t az,
                                        coord_t bx, coord_t by, coord_t bz,
                                        logic [RW-1:0] rad);
    query_t q;
    q.kind = kind;
    q.a = '{ax, ay, az};
    q.b = '{bx, by, bz};
    q.radius = rad;
    return q;
  endfunction

  task automatic set_segment(coord_t sx, coord_t sy, coord_t sz,
                             coord_t ex, coord_t ey, coord_t ez);
    coord_t vals [6];
    vals = '{sx, sy, sz, ex, ey, ez};
    for (int i = 0; i < 6; i++) begin
      @(posedge clk);
      cfg_we   <= 1'b1;
      cfg_idx  <= cfg_reg_t'(i);
      cfg_data <= vals[i];
      seg_regs[i] = vals[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || in_if.valid || answers_q.size() > 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic push_random(int n);
    for (int i = 0; i < n; i++) pending_q.push_back(random_query());
  endtask

  // stimulus
  initial begin
    coord_t mn, mx;
    mn = coord_t'(-8388608);
    mx = coord_t'(8388607);
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_START_X;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.req_type = REQ_SPHERE;
    in_if.obj_ax = '0;
    in_if.obj_ay = '0;
    in_if.obj_az = '0;
    in_if.obj_bx = '0;
    in_if.obj_by = '0;
    in_if.obj_bz = '0;
    in_if.radius = '0;
    out_if.ready = 1'b0;
    hold_tx = 0;
    quiet = 0;
    for (int i = 0; i < 6; i++) seg_regs[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // segment at reset: zero length at origin
    pending_q.push_back(make_query(REQ_SPHERE, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(make_query(REQ_CAPSULE, mn, mn, mn, mx, mx, mx, '1));
    push_random(PHASE_LEN / 2);
    drain();

    // short segment, directed cases first
    set_segment(-4096, 0, 0, 4096, 0, 0);
    pending_q.push_back(make_query(REQ_SPHERE, -4096, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(make_query(REQ_SPHERE, 4096, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(make_query(REQ_SPHERE, -9000, 100, 0, 0, 0, 0, 5000));
    pending_q.push_back(make_query(REQ_SPHERE, 9000, 0, -100, mx, mx, mx, 4904));
    pending_q.push_back(make_query(REQ_SPHERE, 1234, 2048, 0, 0, 0, 0, 2048));
    pending_q.push_back(make_query(REQ_SPHERE, 1234, 2048, 0, 0, 0, 0, 2047));
    pending_q.push_back(make_query(REQ_SPHERE, mn, mn, mn, 0, 0, 0, '1));
    pending_q.push_back(make_query(REQ_SPHERE, mx, mx, mx, mn, mn, mn, '1));
    pending_q.push_back(make_query(REQ_CAPSULE, 0, -4096, 1000, 0, 4096, 1000, 1000));
    pending_q.push_back(make_query(REQ_CAPSULE, 0, -4096, 1000, 0, 4096, 1000, 999));
    pending_q.push_back(make_query(REQ_CAPSULE, -4096, 50, 0, 4096, 50, 0, 60));
    pending_q.push_back(make_query(REQ_CAPSULE, 100, 100, 100, 100, 100, 100, 200));
    pending_q.push_back(make_query(REQ_CAPSULE, 8000, 0, 0, 20000, 0, 0, 4000));
    pending_q.push_back(make_query(REQ_CAPSULE, mn, mn, mn, mn, mx, mn, 0));
    pending_q.push_back(make_query(REQ_CAPSULE, mx, mx, mx, mx, mx, mn, '1));
    pending_q.push_back(make_query(REQ_CAPSULE, mn, mx, mn, mx, mn, mx, '1));
    push_random(PHASE_LEN / 2);
    drain();
    // hold the sender with new requests queued, then release it and drain
    hold_tx = 1;
    push_random(PHASE_LEN / 2);
    repeat (40) @(posedge clk);
    hold_tx = 0;
    drain();

    // full-range diagonal segment
    set_segment(mn, mn, mn, mx, mx, mx);
    push_random(PHASE_LEN);
    drain();

    // small random segment
    set_segment(pick_coord(1), pick_coord(1), pick_coord(1),
                pick_coord(1), pick_coord(1), pick_coord(1));
    push_random(PHASE_LEN);
    drain();

    // degenerate segment away from the origin
    set_segment(3000, -7000, 12000, 3000, -7000, 12000);
    push_random(PHASE_LEN);
    drain();

    // anti-diagonal extremes, then a stretch with no idling
    set_segment(mx, mn, mx, mn, mx, mn);
    push_random(PHASE_LEN / 2);
    drain();
    set_segment(pick_coord(0), pick_coord(0), pick_coord(0),
                pick_coord(0), pick_coord(0), pick_coord(0));
    quiet = 1;
    push_random(PHASE_LEN / 2);
    drain();

    $display("checked %0d results: %0d sphere and %0d capsule queries, %0d hits",
             n_checked, n_sphere, n_capsule, n_hit);
    $display("%0d saturated distances over seven segment settings", n_sat);
    if (errors == 0) begin
      $display("segment_sphere_capsule_test verification clean");
    end else begin
      $display("segment_sphere_capsule_test verification failed");
    end
    $finish;
  end

endmodule

// ===== segment_sphere_capsule_test.f =====
sv/ssct_pkg.sv
sv/ssct_if.sv
sv/ssct_wmul.sv
sv/ssct_div.sv
sv/ssct_point.sv
sv/ssct_front.sv
sv/segment_sphere_capsule_test.sv
dv/tb_segment_sphere_capsule_test.sv
